### rtl/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg
// Types and constants shared by the pulse distance IR transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int MAX_BITS_DEF             = 64;
  localparam int CARRIER_HALF_TICKS_DEF   = 13;
  localparam int CARRIER_PERIOD_TICKS_DEF = 26;

  localparam int CODE_W  = 64;
  localparam int COUNT_W = 7;
  localparam int TIME_W  = 16;
  localparam int CFG_IDX_W = 4;

  // Register reset values, in microseconds
  localparam logic [TIME_W-1:0] RST_HDR_MARK  = 16'd9000;
  localparam logic [TIME_W-1:0] RST_HDR_SPACE = 16'd4500;
  localparam logic [TIME_W-1:0] RST_ZERO_MARK = 16'd562;
  localparam logic [TIME_W-1:0] RST_ZERO_SPACE = 16'd562;
  localparam logic [TIME_W-1:0] RST_ONE_MARK  = 16'd562;
  localparam logic [TIME_W-1:0] RST_ONE_SPACE = 16'd1687;
  localparam logic [TIME_W-1:0] RST_FTR_MARK  = 16'd562;
  localparam logic [TIME_W-1:0] RST_FTR_SPACE = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_MARK   = 4'd0,
    CFG_HDR_SPACE  = 4'd1,
    CFG_ZERO_MARK  = 4'd2,
    CFG_ZERO_SPACE = 4'd3,
    CFG_ONE_MARK   = 4'd4,
    CFG_ONE_SPACE  = 4'd5,
    CFG_FTR_MARK   = 4'd6,
    CFG_FTR_SPACE  = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_FTR_MARK  = 3'd5,
    PH_FTR_SPACE = 3'd6
  } phase_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [CODE_W-1:0]  code_word;
    logic [COUNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic ir_out;
    logic busy_res;
    logic done_res;
    logic rejected;
  } out_item_t;

endpackage

### rtl/ir_pulse_distance_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Pulse distance IR encoder stepped by one-microsecond tick transfers.
// ----------------------------------------------------------------------------
// Usage: send a start transfer with the code word and bit count, then one tick
// transfer per microsecond. Every input transfer yields exactly one result
// transfer carrying the emitter level for that tick plus busy, done and
// rejected flags. The block takes one transfer per clock when not stalled,
// and each result is registered; a two-entry output (result register plus
// skid) lets it keep accepting while a result waits. Input stall rises
// only when the skid is occupied, or while zero-length segments are being
// skipped (the skip walk checks one segment per clock, so with a fully zero
// bit table the input stays stalled while every segment of the item is passed
// over). With nonzero timings no skip clocks occur. Marks are whole carrier
// periods: the raw microsecond count runs down while the carrier phase
// counter cycles, and the mark ends at the first period boundary after the
// count reaches zero. Timing registers are sampled when a segment begins.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_unit #(
  parameter int MAX_BITS             = irpdt_pkg::MAX_BITS_DEF,
  parameter int CARRIER_HALF_TICKS   = irpdt_pkg::CARRIER_HALF_TICKS_DEF,
  parameter int CARRIER_PERIOD_TICKS = irpdt_pkg::CARRIER_PERIOD_TICKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  irpdt_pkg::in_item_t                 in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output irpdt_pkg::out_item_t                out_data,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpdt_pkg::TIME_W-1:0]        cfg_data
);
  import irpdt_pkg::*;

  localparam int BC_W  = $clog2(MAX_BITS + 1);
  localparam int POS_W = (CARRIER_PERIOD_TICKS > 1) ? $clog2(CARRIER_PERIOD_TICKS) : 1;

  // Timing registers
  logic [TIME_W-1:0] hdr_mark_r, hdr_space_r, zero_mark_r, zero_space_r;
  logic [TIME_W-1:0] one_mark_r, one_space_r, ftr_mark_r, ftr_space_r;

  // Sequencer state
  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [MAX_BITS-1:0] shift_r, shift_nxt;
  logic [BC_W-1:0]     bits_r, bits_nxt;
  // Skip walk: phase_r holds a zero-length segment still to be passed over
  logic                settle_r, settle_nxt;
  logic                pend_tick_r, pend_tick_nxt;
  logic                pend_level_r, pend_level_nxt;

  // Output register and skid
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;

  logic      in_acc;
  logic      res_vld;
  out_item_t res;

  // Candidate next segment
  logic                do_check, use_after, item_tick, item_level;
  phase_t              aft_phase, cand_phase;
  logic [MAX_BITS-1:0] aft_shift, cand_shift, load_shift;
  logic [BC_W-1:0]     aft_bits, cand_bits, load_bits, aft_bits_dec;
  logic [TIME_W-1:0]   cand_len, time_dec;
  logic                is_mark, pos_wrap;

  assign in_stall  = settle_r | skid_valid_r;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Configuration registers; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= RST_HDR_MARK;
      hdr_space_r  <= RST_HDR_SPACE;
      zero_mark_r  <= RST_ZERO_MARK;
      zero_space_r <= RST_ZERO_SPACE;
      one_mark_r   <= RST_ONE_MARK;
      one_space_r  <= RST_ONE_SPACE;
      ftr_mark_r   <= RST_FTR_MARK;
      ftr_space_r  <= RST_FTR_SPACE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_MARK:   hdr_mark_r   <= cfg_data;
        CFG_HDR_SPACE:  hdr_space_r  <= cfg_data;
        CFG_ZERO_MARK:  zero_mark_r  <= cfg_data;
        CFG_ZERO_SPACE: zero_space_r <= cfg_data;
        CFG_ONE_MARK:   one_mark_r   <= cfg_data;
        CFG_ONE_SPACE:  one_space_r  <= cfg_data;
        CFG_FTR_MARK:   ftr_mark_r   <= cfg_data;
        CFG_FTR_SPACE:  ftr_space_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Start load: saturate bit count, left-align the used bits
  // --------------------------------------------------------------------------
  always_comb begin
    if (32'(in_data.bit_count) > 32'(MAX_BITS)) begin
      load_bits = BC_W'(MAX_BITS);
    end else begin
      load_bits = BC_W'(in_data.bit_count);
    end
    load_shift = in_data.code_word[MAX_BITS-1:0] << (BC_W'(MAX_BITS) - load_bits);
  end

  // --------------------------------------------------------------------------
  // Segment that follows the current one. A zero footer space goes straight
  // to idle, since idle ends the walk anyway.
  // --------------------------------------------------------------------------
  assign aft_bits_dec = (bits_r != '0) ? bits_r - BC_W'(1) : bits_r;

  always_comb begin
    aft_shift = shift_r;
    aft_bits  = bits_r;
    case (phase_r)
      PH_HDR_MARK:  aft_phase = PH_HDR_SPACE;
      PH_HDR_SPACE: aft_phase = (bits_r != '0) ? PH_BIT_MARK : PH_FTR_MARK;
      PH_BIT_MARK:  aft_phase = PH_BIT_SPACE;
      PH_BIT_SPACE: begin
        aft_shift = shift_r << 1;
        aft_bits  = aft_bits_dec;
        aft_phase = (aft_bits_dec != '0) ? PH_BIT_MARK : PH_FTR_MARK;
      end
      PH_FTR_MARK:  aft_phase = (ftr_space_r != '0) ? PH_FTR_SPACE : PH_IDLE;
      default:      aft_phase = PH_IDLE;
    endcase
  end

  always_comb begin
    if (use_after) begin
      cand_phase = aft_phase;
      cand_shift = aft_shift;
      cand_bits  = aft_bits;
    end else begin
      cand_phase = PH_HDR_MARK;
      cand_shift = load_shift;
      cand_bits  = load_bits;
    end
  end

  // Raw length of the candidate; marks are rounded by the carrier counter
  always_comb begin
    case (cand_phase)
      PH_HDR_MARK:  cand_len = hdr_mark_r;
      PH_HDR_SPACE: cand_len = hdr_space_r;
      PH_BIT_MARK:  cand_len = cand_shift[MAX_BITS-1] ? one_mark_r : zero_mark_r;
      PH_BIT_SPACE: cand_len = cand_shift[MAX_BITS-1] ? one_space_r : zero_space_r;
      PH_FTR_MARK:  cand_len = ftr_mark_r;
      PH_FTR_SPACE: cand_len = ftr_space_r;
      default:      cand_len = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-transfer step
  // --------------------------------------------------------------------------
  assign is_mark  = (phase_r == PH_HDR_MARK) || (phase_r == PH_BIT_MARK) ||
                    (phase_r == PH_FTR_MARK);
  assign pos_wrap = (pos_r == POS_W'(CARRIER_PERIOD_TICKS - 1));
  assign time_dec = (time_r != '0) ? time_r - TIME_W'(1) : time_r;

  always_comb begin
    phase_nxt      = phase_r;
    time_nxt       = time_r;
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    bits_nxt       = bits_r;
    settle_nxt     = settle_r;
    pend_tick_nxt  = pend_tick_r;
    pend_level_nxt = pend_level_r;
    res_vld        = 1'b0;
    res            = '0;
    do_check       = 1'b0;
    use_after      = 1'b0;
    item_tick      = 1'b0;
    item_level     = 1'b0;

    if (settle_r) begin
      // keep walking past zero-length segments
      do_check   = 1'b1;
      use_after  = 1'b1;
      item_tick  = pend_tick_r;
      item_level = pend_level_r;
    end else if (in_acc) begin
      if (in_data.operation == OP_START) begin
        if (phase_r != PH_IDLE) begin
          res_vld      = 1'b1;
          res.rejected = 1'b1;
          res.busy_res = 1'b1;
        end else begin
          do_check = 1'b1;
        end
      end else if (phase_r == PH_IDLE) begin
        res_vld = 1'b1;
      end else begin
        item_tick  = 1'b1;
        item_level = is_mark && (32'(pos_r) < 32'(CARRIER_HALF_TICKS));
        pos_nxt    = pos_wrap ? '0 : pos_r + POS_W'(1);
        time_nxt   = time_dec;
        if (time_dec == '0 && (!is_mark || pos_wrap)) begin
          do_check  = 1'b1;
          use_after = 1'b1;
        end else begin
          res_vld      = 1'b1;
          res.ir_out   = item_level;
          res.busy_res = 1'b1;
        end
      end
    end

    if (do_check) begin
      phase_nxt = cand_phase;
      shift_nxt = cand_shift;
      bits_nxt  = cand_bits;
      pos_nxt   = '0;
      if (cand_phase == PH_IDLE || cand_len != '0) begin
        settle_nxt   = 1'b0;
        time_nxt     = (cand_phase == PH_IDLE) ? '0 : cand_len;
        res_vld      = 1'b1;
        res.ir_out   = item_level;
        res.busy_res = item_tick | (cand_phase != PH_IDLE);
        res.done_res = (cand_phase == PH_IDLE);
      end else begin
        settle_nxt     = 1'b1;
        time_nxt       = '0;
        pend_tick_nxt  = item_tick;
        pend_level_nxt = item_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      time_r   <= '0;
      pos_r    <= '0;
      shift_r  <= '0;
      bits_r   <= '0;
      settle_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      time_r   <= time_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      settle_r <= settle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_tick_r  <= pend_tick_nxt;
    pend_level_r <= pend_level_nxt;
  end

  // --------------------------------------------------------------------------
  // Result register with skid. A new result only appears while the skid is
  // empty, because the input stalls whenever it is full.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (res_vld) begin
      skid_data_r <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the result register is empty");

  a_no_result_on_full_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_vld)
    else $error("result produced while skid is full");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (time_r == '0 && !settle_r))
    else $error("idle phase with pending time or skip walk");

  a_carrier_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < 32'(CARRIER_PERIOD_TICKS))
    else $error("carrier position out of range");

  a_reject_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.rejected) |-> (out_data_r.busy_res && !out_data_r.done_res))
    else $error("rejected start reported as done");

endmodule
